/* rtl/ipdp_pkg.sv */
// ----------------------------------------------------------------------------
// ipdp_pkg
// Types, constants and character helpers for the IPv4 dotted text parser.
// ----------------------------------------------------------------------------
package ipdp_pkg;

  typedef enum logic [3:0] {
    PH_START   = 4'b0001,
    PH_ZERO    = 4'b0010,
    PH_DIGITS  = 4'b0100,
    PH_DISCARD = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_e;

  localparam int unsigned NumParts = 3;

  typedef logic [31:0] part_t;
  typedef part_t [NumParts-1:0] parts_t;

  typedef struct packed {
    phase_e      phase;
    radix_e      radix;
    logic [31:0] value;
    logic [1:0]  count;
  } state_t;

  typedef struct packed {
    logic       we;
    logic [1:0] idx;
  } part_wr_t;

  localparam state_t StateReset = '{
    phase: PH_START,
    radix: RX_DEC,
    value: 32'd0,
    count: 2'd0
  };

  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChDot  = 8'h2E;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChXLo  = 8'h78;
  localparam logic [7:0] ChXUp  = 8'h58;

  localparam logic [31:0] Max8  = 32'h0000_00ff;
  localparam logic [31:0] Max16 = 32'h0000_ffff;
  localparam logic [31:0] Max24 = 32'h00ff_ffff;

  localparam logic [4:0] HexNone = 5'd16;

  function automatic logic is_dec(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  // digit value 0..15, or HexNone
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = HexNone;
    if (c inside {[8'h30:8'h39]}) begin
      r = 5'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      r = 5'(c - 8'h61 + 8'd10);
    end else if (c inside {[8'h41:8'h46]}) begin
      r = 5'(c - 8'h41 + 8'd10);
    end
    return r;
  endfunction

endpackage

/* rtl/ipdp_parts.sv */
// ----------------------------------------------------------------------------
// ipdp_parts
// Holds the finished dotted parts of the address being parsed.
// ----------------------------------------------------------------------------
module ipdp_parts (
  input  logic              clk_i,
  input  ipdp_pkg::part_wr_t wr_i,
  input  logic [31:0]       data_i,
  output ipdp_pkg::parts_t  parts_o
);
  import ipdp_pkg::*;

  parts_t parts_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      case (wr_i.idx)
        2'd0:    parts_q[0] <= data_i;
        2'd1:    parts_q[1] <= data_i;
        2'd2:    parts_q[2] <= data_i;
        default: ;
      endcase
    end
  end

  assign parts_o = parts_q;

endmodule

/* rtl/ipdp_step.sv */
// ----------------------------------------------------------------------------
// ipdp_step
// Next-state and result logic for one character of the address text.
// ----------------------------------------------------------------------------
module ipdp_step (
  input  logic [7:0]         ch_i,
  input  ipdp_pkg::state_t   state_i,
  input  ipdp_pkg::parts_t   parts_i,
  output ipdp_pkg::state_t   state_o,
  output ipdp_pkg::part_wr_t part_wr_o,
  output logic               emit_o,
  output logic               ok_o,
  output logic [31:0]        addr_o
);
  import ipdp_pkg::*;

  logic [31:0] v;
  logic [31:0] times_ten;
  logic [31:0] dec_next;
  logic [31:0] digit;
  logic [4:0]  hv;
  radix_e      eff_radix;
  logic        end_ok;
  logic [31:0] end_addr;

  assign v         = state_i.value;
  assign hv        = hex_val(ch_i);
  assign digit     = {28'd0, ch_i[3:0]};
  assign times_ten = {v[28:0], 3'b000} + {v[30:0], 1'b0};
  assign eff_radix = (state_i.phase == PH_ZERO) ? RX_OCT : state_i.radix;

  always_comb begin
    case (eff_radix)
      RX_OCT:  dec_next = {v[28:0], 3'b000} + digit;
      RX_HEX:  dec_next = {v[27:0], 4'b0000} + digit;
      default: dec_next = times_ten + digit;
    endcase
  end

  // range check and assembly at end of text
  always_comb begin
    end_ok   = 1'b1;
    end_addr = v;
    case (state_i.count)
      2'd0: begin
        end_ok   = 1'b1;
        end_addr = v;
      end
      2'd1: begin
        end_ok   = (v <= Max24) && (parts_i[0] <= Max8);
        end_addr = v | {parts_i[0][7:0], 24'd0};
      end
      2'd2: begin
        end_ok   = (v <= Max16) && (parts_i[0] <= Max8) && (parts_i[1] <= Max8);
        end_addr = v | {parts_i[0][7:0], parts_i[1][7:0], 16'd0};
      end
      default: begin
        end_ok   = (v <= Max8) && (parts_i[0] <= Max8) && (parts_i[1] <= Max8)
                   && (parts_i[2] <= Max8);
        end_addr = v | {parts_i[0][7:0], parts_i[1][7:0], parts_i[2][7:0], 8'd0};
      end
    endcase
  end

  always_comb begin
    state_o   = state_i;
    part_wr_o = '{we: 1'b0, idx: state_i.count};
    emit_o    = 1'b0;
    ok_o      = 1'b0;
    addr_o    = 32'd0;
    case (state_i.phase)
      PH_DISCARD: begin
        if (ch_i == ChNul) state_o = StateReset;
      end
      PH_ZERO, PH_DIGITS: begin
        if ((state_i.phase == PH_ZERO) && (ch_i == ChXLo || ch_i == ChXUp)) begin
          state_o.radix = RX_HEX;
          state_o.phase = PH_DIGITS;
        end else if (is_dec(ch_i)) begin
          state_o.radix = eff_radix;
          state_o.phase = PH_DIGITS;
          state_o.value = dec_next;
        end else if ((eff_radix == RX_HEX) && (hv != HexNone)) begin
          state_o.phase = PH_DIGITS;
          state_o.value = {v[27:0], hv[3:0]};
        end else if (ch_i == ChDot) begin
          if (state_i.count == 2'd3) begin
            emit_o  = 1'b1;
            state_o = StateReset;
            state_o.phase = PH_DISCARD;
          end else begin
            part_wr_o.we  = 1'b1;
            state_o.count = state_i.count + 2'd1;
            state_o.value = 32'd0;
            state_o.radix = RX_DEC;
            state_o.phase = PH_START;
          end
        end else begin
          // end of text on NUL or whitespace, anything else is bad
          emit_o  = 1'b1;
          state_o = StateReset;
          if (ch_i == ChNul || is_space(ch_i)) begin
            ok_o   = end_ok;
            addr_o = end_ok ? end_addr : 32'd0;
          end
          if (ch_i != ChNul) state_o.phase = PH_DISCARD;
        end
      end
      default: begin
        if (!is_dec(ch_i)) begin
          emit_o  = 1'b1;
          state_o = StateReset;
          if (ch_i != ChNul) state_o.phase = PH_DISCARD;
        end else begin
          state_o.radix = RX_DEC;
          state_o.value = digit;
          state_o.phase = (ch_i == ChZero) ? PH_ZERO : PH_DIGITS;
        end
      end
    endcase
  end

endmodule

/* rtl/ipv4_dotted_text_parser.sv */
// An accepted character is held in the input register; its result is captured in the output register.
// Throughput: one character per cycle unless stalled; the parse state updates once per item.
// Input stalls only while the output register holds a result that is itself stalled.
// Reset clears the input/output valid flags and the parse state (phase, radix, value, count).
// The finished-part registers have no reset; they are always written before being read.
// ----------------------------------------------------------------------------
// ipv4_dotted_text_parser
// Streaming dotted-quad address parser: characters in, one address result per string.
// ----------------------------------------------------------------------------
module ipv4_dotted_text_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        valid_res_o,
  output logic [31:0] address_o
);
  import ipdp_pkg::*;

  logic        in_valid_q;
  logic [7:0]  ch_q;
  state_t      state_q, state_d;
  parts_t      parts;
  part_wr_t    part_wr, part_wr_gated;
  logic        emit, ok;
  logic [31:0] addr;
  logic        advance, fire;
  logic        out_valid_q;
  logic        out_ok_q;
  logic [31:0] out_addr_q;

  // hold the registered item while the result slot is stuck
  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign fire       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) ch_q <= ch_i;
  end

  ipdp_step u_step (
    .ch_i      (ch_q),
    .state_i   (state_q),
    .parts_i   (parts),
    .state_o   (state_d),
    .part_wr_o (part_wr),
    .emit_o    (emit),
    .ok_o      (ok),
    .addr_o    (addr)
  );

  assign part_wr_gated = '{we: part_wr.we && fire, idx: part_wr.idx};

  ipdp_parts u_parts (
    .clk_i   (clk_i),
    .wr_i    (part_wr_gated),
    .data_i  (state_q.value),
    .parts_o (parts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_ok_q   <= ok;
      out_addr_q <= addr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = out_ok_q;
  assign address_o   = out_addr_q;

endmodule

/* tb/ipv4_parse_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_parse_checker
// Watches the character and result channels of the dotted text parser. It
// keeps its own copy of the parse state, works out the result that each
// accepted character causes and compares every delivered result with the
// oldest one still waiting.
// ----------------------------------------------------------------------------
module ipv4_parse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  ch_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        valid_res_i,
  input  logic [31:0] address_i,
  output int          pending_o,
  output int          errors_o
);
  import ipdp_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } addr_result_t;

  addr_result_t expected_addr_q[$];
  int           mismatches = 0;

  // parse state of the predictor
  phase_e      ph;
  radix_e      rdx;
  logic [31:0] acc_value;
  logic [31:0] parts [NumParts];
  logic [1:0]  nparts;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  task automatic clear_parse();
    ph        = PH_START;
    rdx       = RX_DEC;
    acc_value = 32'd0;
    nparts    = 2'd0;
    foreach (parts[i]) parts[i] = 32'd0;
  endtask

  // queue one result, then restart or drop characters up to the next NUL
  task automatic close_string(input logic [7:0] c, input logic ok, input logic [31:0] addr);
    expected_addr_q.push_back('{ok: ok, addr: ok ? addr : 32'd0});
    clear_parse();
    if (c != ChNul) ph = PH_DISCARD;
  endtask

  task automatic take_part_char(input logic [7:0] c);
    logic [31:0] base;
    logic [31:0] joined;
    logic        in_range;
    if (is_digit(c)) begin
      case (rdx)
        RX_HEX:  base = 32'd16;
        RX_OCT:  base = 32'd8;
        default: base = 32'd10;
      endcase
      acc_value = acc_value * base + 32'(c - ChZero);
    end else if (rdx == RX_HEX &&
                 ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))) begin
      // a..f and A..F share the low nibble 1..6
      acc_value = {acc_value[27:0], c[3:0] + 4'd9};
    end else if (c == ChDot) begin
      if (nparts == 2'd3) begin
        close_string(c, 1'b0, 32'd0);
      end else begin
        parts[nparts] = acc_value;
        nparts        = nparts + 2'd1;
        acc_value     = 32'd0;
        rdx           = RX_DEC;
        ph            = PH_START;
      end
    end else if (c == ChNul || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
      case (nparts)
        2'd0: begin
          in_range = 1'b1;
          joined   = acc_value;
        end
        2'd1: begin
          in_range = acc_value <= Max24 && parts[0] <= Max8;
          joined   = acc_value | (parts[0] << 24);
        end
        2'd2: begin
          in_range = acc_value <= Max16 && parts[0] <= Max8 && parts[1] <= Max8;
          joined   = acc_value | (parts[0] << 24) | (parts[1] << 16);
        end
        default: begin
          in_range = acc_value <= Max8 && parts[0] <= Max8 && parts[1] <= Max8 &&
                     parts[2] <= Max8;
          joined   = acc_value | (parts[0] << 24) | (parts[1] << 16) | (parts[2] << 8);
        end
      endcase
      close_string(c, in_range, joined);
    end else begin
      close_string(c, 1'b0, 32'd0);
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    case (ph)
      PH_DISCARD: begin
        if (c == ChNul) clear_parse();
      end
      PH_ZERO: begin
        rdx = RX_OCT;
        ph  = PH_DIGITS;
        if (c == ChXLo || c == ChXUp) rdx = RX_HEX;
        else take_part_char(c);
      end
      PH_DIGITS: take_part_char(c);
      default: begin
        if (!is_digit(c)) begin
          close_string(c, 1'b0, 32'd0);
        end else begin
          rdx       = RX_DEC;
          acc_value = 32'(c - ChZero);
          ph        = (c == ChZero) ? PH_ZERO : PH_DIGITS;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    addr_result_t want;
    if (!rst_ni) begin
      clear_parse();
      expected_addr_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_addr_q.size() == 0) begin
          report_mismatch($sformatf("result %0b/%08h with no item waiting",
                                    valid_res_i, address_i));
        end else begin
          want = expected_addr_q.pop_front();
          if (valid_res_i !== want.ok)
            report_mismatch($sformatf("valid_res %0b, expected %0b", valid_res_i, want.ok));
          if (address_i !== want.addr)
            report_mismatch($sformatf("address %08h, expected %08h", address_i, want.addr));
        end
      end
      if (in_valid_i && !in_stall_i) parse_char(ch_i);
    end
    pending_o <= expected_addr_q.size();
    errors_o  <= mismatches;
  end

endmodule

/* tb/tb_ipv4_dotted_text_parser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_dotted_text_parser
// Feeds address text to the parser one character per item: a few directed
// strings for the corner cases, then random dotted addresses in every radix
// mixed with broken strings and noise, under random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_ipv4_dotted_text_parser;
  import ipdp_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  ch_i        = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        valid_res_o;
  logic [31:0] address_o;

  int          waiting_results;
  int          mismatch_count;

  logic [7:0]  line_q[$];
  int          chars_sent = 0;
  int unsigned gap_top    = 4;

  ipv4_dotted_text_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .valid_res_o (valid_res_o),
    .address_o   (address_o)
  );

  ipv4_parse_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .ch_i        (ch_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .valid_res_i (valid_res_o),
    .address_i   (address_o),
    .pending_o   (waiting_results),
    .errors_o    (mismatch_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    gap = $urandom_range(0, gap_top);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
    line_q.delete();
  endtask

  // one dotted part in a random radix, with values near the range limits
  function automatic string part_text();
    logic [31:0] v;
    string       s;
    string       body;
    string       hex_chars;
    int unsigned n;
    hex_chars = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 7))
          0: v = 32'h0;
          1: v = 32'hff;
          2: v = 32'h100;
          3: v = 32'hffff;
          4: v = 32'h1_0000;
          5: v = 32'hff_ffff;
          6: v = 32'h100_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      1: v = $urandom();
      2, 3: v = $urandom_range(0, 32'hffff);
      default: v = $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 9))
      5, 6: s = $sformatf("0%0o", v);
      7, 8: begin
        body = $sformatf("%0h", v);
        if ($urandom_range(0, 1)) body = body.toupper();
        s = {($urandom_range(0, 1) ? "0x" : "0X"), body};
      end
      9: begin
        // raw digit runs: wraparound, octal with 8 and 9, empty hex
        s = "";
        if ($urandom_range(0, 1)) begin
          n = $urandom_range(1, 12);
          repeat (n) s = $sformatf("%s%c", s, 8'($urandom_range(8'h30, 8'h39)));
        end else begin
          s = "0x";
          n = $urandom_range(0, 10);
          repeat (n) s = $sformatf("%s%c", s, hex_chars[$urandom_range(0, 21)]);
        end
      end
      default: s = $sformatf("%0d", v);
    endcase
    return s;
  endfunction

  task automatic build_random_line();
    string       s;
    int unsigned nparts;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // noise: any bytes, then end the string
      repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(ChNul);
      return;
    end
    nparts = ($urandom_range(0, 15) == 0) ? 5 : $urandom_range(1, 4);
    s = part_text();
    for (int i = 1; i < nparts; i++) s = {s, ".", part_text()};
    push_text(s);
    if (pick < 25) begin
      line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (pick < 45) begin
      // whitespace end, then trailing bytes to drop
      pick = $urandom_range(0, 5);
      line_q.push_back((pick == 0) ? 8'h20 : 8'(8'h09 + pick - 1));
      repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(1, 255)));
    end
    line_q.push_back(ChNul);
  endtask

  // receiver: random stalls, one long hold-off to back the block up
  initial begin : drain
    int unsigned hold;
    int unsigned taken;
    int unsigned stall_top;
    taken     = 0;
    stall_top = 4;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) stall_top = ($urandom_range(0, 2) == 0) ? 0 : 4;
      hold = (taken == 30) ? 300 : $urandom_range(0, stall_top);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_text("x");        line_q.push_back(ChNul);  // non-digit opens a part
    push_text("0x");       line_q.push_back(ChNul);  // hex prefix alone is zero
    push_text("1.2.3.4."); line_q.push_back(ChNul);  // fifth part
    push_text("9z");       line_q.push_back(ChNul);  // bad character inside a part
    line_q.push_back(8'hff); line_q.push_back(ChNul);
    push_text("7 ");       line_q.push_back(ChNul);  // whitespace end, then drop
    send_line();

    while (chars_sent < 1300) begin
      if (chars_sent % 150 < 8) gap_top = $urandom_range(0, 2) * 2;
      build_random_line();
      send_line();
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (waiting_results != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
